[rtl/dtd_pkg.sv]
// shared types and constants for the decimal text to double parser
// no dependencies; imported by every module of the block
package dtd_pkg;

    localparam int EXP_LIMIT_DEF = 511;
    localparam int EXP_CNT_W     = 12;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [63:0] DBL_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_TEN  = 64'h4024_0000_0000_0000;
    localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        FP_MUL,
        FP_DIV,
        FP_ADD
    } fp_op_t;

    typedef struct packed {
        logic        valid;
        fp_op_t      op;
        logic [63:0] a;
        logic [63:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fpu_rsp_t;

    // one command from the parser to the arithmetic side
    typedef struct packed {
        logic                 add_digit;
        logic                 frac;
        logic [3:0]           digit;
        logic                 finish;
        logic                 mant_neg;
        logic                 exp_neg;
        logic [EXP_CNT_W-1:0] exp_count;
    } cmd_t;

endpackage

[rtl/dtd_fpu.sv]
// sequential double precision unit: multiply, divide and add, round to nearest even
// depends on dtd_pkg
module dtd_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  dtd_pkg::fpu_req_t req,
    output dtd_pkg::fpu_rsp_t rsp
);
    import dtd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM_A,
        S_NORM_B,
        S_EXEC,
        S_MUL_FIN,
        S_NORM,
        S_ROUND
    } state_t;

    state_t              state_reg;
    fp_op_t              op_reg;
    logic                sign_reg;
    logic signed [13:0]  ea_reg;
    logic signed [13:0]  eb_reg;
    logic        [52:0]  ma_reg;
    logic        [52:0]  mb_reg;
    logic        [56:0]  sig_reg;
    logic                sticky_reg;
    logic signed [13:0]  re_reg;
    logic        [105:0] acc_reg;
    logic        [54:0]  rem_reg;
    logic        [5:0]   cnt_reg;
    logic        [63:0]  result_reg;
    logic                done_reg;

    // operand decode
    logic [10:0] ex_a, ex_b;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        sgn;
    logic        spec_hit;
    logic [63:0] spec_val;

    always_comb
    begin
        ex_a   = req.a[62:52];
        ex_b   = req.b[62:52];
        a_nan  = (ex_a == 11'h7FF) && (req.a[51:0] != 52'd0);
        b_nan  = (ex_b == 11'h7FF) && (req.b[51:0] != 52'd0);
        a_inf  = (ex_a == 11'h7FF) && (req.a[51:0] == 52'd0);
        b_inf  = (ex_b == 11'h7FF) && (req.b[51:0] == 52'd0);
        a_zero = (req.a[62:0] == 63'd0);
        b_zero = (req.b[62:0] == 63'd0);
        sgn    = (req.op == FP_ADD) ? req.a[63] : (req.a[63] ^ req.b[63]);
        spec_hit = 1'b0;
        spec_val = DBL_QNAN;
        case (req.op)
            FP_MUL:
            begin
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                begin
                    spec_hit = 1'b1;
                end
                else if (a_inf || b_inf)
                begin
                    spec_hit = 1'b1;
                    spec_val = {sgn, DBL_INF[62:0]};
                end
                else if (a_zero || b_zero)
                begin
                    spec_hit = 1'b1;
                    spec_val = {sgn, 63'd0};
                end
            end
            FP_DIV:
            begin
                if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
                begin
                    spec_hit = 1'b1;
                end
                else if (a_inf || b_zero)
                begin
                    spec_hit = 1'b1;
                    spec_val = {sgn, DBL_INF[62:0]};
                end
                else if (a_zero || b_inf)
                begin
                    spec_hit = 1'b1;
                    spec_val = {sgn, 63'd0};
                end
            end
            FP_ADD:
            begin
                if (a_nan || b_nan)
                begin
                    spec_hit = 1'b1;
                end
                else if (a_inf || b_inf)
                begin
                    spec_hit = 1'b1;
                    spec_val = {sgn, DBL_INF[62:0]};
                end
                else if (a_zero)
                begin
                    spec_hit = 1'b1;
                    spec_val = req.b;
                end
                else if (b_zero)
                begin
                    spec_hit = 1'b1;
                    spec_val = req.a;
                end
            end
            default:
            begin
                spec_hit = 1'b1;
            end
        endcase
    end

    // one 27x27 partial product per cycle
    logic [26:0]  pa, pb;
    logic [53:0]  pp;
    logic [105:0] ppw;

    always_comb
    begin
        pa  = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        pb  = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp  = pa * pb;
        case (cnt_reg[1:0])
            2'd0:    ppw = {52'd0, pp};
            2'd3:    ppw = {pp[51:0], 54'd0};
            default: ppw = {25'd0, pp, 27'd0};
        endcase
    end

    // restoring divide step
    logic        ge;
    logic [54:0] rem_sub;
    logic [54:0] rem_next;

    always_comb
    begin
        ge       = rem_reg >= {2'b00, mb_reg};
        rem_sub  = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
        rem_next = {rem_sub[53:0], 1'b0};
    end

    // same sign add with alignment
    logic                a_big;
    logic        [52:0]  big_m, small_m;
    logic signed [13:0]  big_e, diff;
    logic        [5:0]   sh;
    logic        [55:0]  small_w, shifted, lost_mask;
    logic                add_st;
    logic        [56:0]  sum;

    always_comb
    begin
        a_big     = ea_reg >= eb_reg;
        big_m     = a_big ? ma_reg : mb_reg;
        small_m   = a_big ? mb_reg : ma_reg;
        big_e     = a_big ? ea_reg : eb_reg;
        diff      = a_big ? (ea_reg - eb_reg) : (eb_reg - ea_reg);
        sh        = (diff > 14'sd56) ? 6'd57 : diff[5:0];
        small_w   = {small_m, 3'b000};
        shifted   = small_w >> sh;
        lost_mask = (56'd1 << sh) - 56'd1;
        add_st    = |(small_w & lost_mask);
        sum       = {1'b0, big_m, 3'b000} + {1'b0, shifted};
    end

    // rounding and packing
    logic        inc;
    logic [53:0] m54;
    logic signed [13:0] e_r;
    logic [51:0] fr;
    logic        hidden;
    logic [63:0] packed_val;

    always_comb
    begin
        inc = sig_reg[2] & (sig_reg[3] | sig_reg[1] | sig_reg[0] | sticky_reg);
        m54 = {1'b0, sig_reg[55:3]} + {53'd0, inc};
        if (m54[53])
        begin
            e_r = re_reg + 14'sd1;
            fr  = m54[52:1];
        end
        else
        begin
            e_r = re_reg;
            fr  = m54[51:0];
        end
        hidden = m54[53] | m54[52];
        if (e_r >= 14'sd2047)
        begin
            packed_val = {sign_reg, DBL_INF[62:0]};
        end
        else if (!hidden)
        begin
            packed_val = {sign_reg, 11'd0, fr};
        end
        else
        begin
            packed_val = {sign_reg, e_r[10:0], fr};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= FP_MUL;
            sign_reg   <= 1'b0;
            ea_reg     <= '0;
            eb_reg     <= '0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            sig_reg    <= '0;
            sticky_reg <= 1'b0;
            re_reg     <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            result_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg   <= req.op;
                        sign_reg <= sgn;
                        ea_reg   <= (ex_a == 11'd0) ? 14'sd1 : $signed({3'b000, ex_a});
                        eb_reg   <= (ex_b == 11'd0) ? 14'sd1 : $signed({3'b000, ex_b});
                        ma_reg   <= {ex_a != 11'd0, req.a[51:0]};
                        mb_reg   <= {ex_b != 11'd0, req.b[51:0]};
                        if (spec_hit)
                        begin
                            result_reg <= spec_val;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_NORM_A;
                        end
                    end
                end
                S_NORM_A:
                begin
                    // subnormal operands are brought up one bit a cycle
                    if (ma_reg[52])
                    begin
                        state_reg <= S_NORM_B;
                    end
                    else
                    begin
                        ma_reg <= {ma_reg[51:0], 1'b0};
                        ea_reg <= ea_reg - 14'sd1;
                    end
                end
                S_NORM_B:
                begin
                    if (mb_reg[52])
                    begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        rem_reg   <= {2'b00, ma_reg};
                        state_reg <= S_EXEC;
                    end
                    else
                    begin
                        mb_reg <= {mb_reg[51:0], 1'b0};
                        eb_reg <= eb_reg - 14'sd1;
                    end
                end
                S_EXEC:
                begin
                    case (op_reg)
                        FP_MUL:
                        begin
                            acc_reg <= acc_reg + ppw;
                            cnt_reg <= cnt_reg + 6'd1;
                            if (cnt_reg == 6'd3)
                            begin
                                state_reg <= S_MUL_FIN;
                            end
                        end
                        FP_DIV:
                        begin
                            sig_reg <= {sig_reg[55:0], ge};
                            rem_reg <= rem_next;
                            cnt_reg <= cnt_reg + 6'd1;
                            if (cnt_reg == 6'd56)
                            begin
                                sticky_reg <= |rem_next;
                                re_reg     <= ea_reg - eb_reg + 14'sd1022;
                                state_reg  <= S_NORM;
                            end
                        end
                        FP_ADD:
                        begin
                            sig_reg    <= sum;
                            sticky_reg <= add_st;
                            re_reg     <= big_e;
                            state_reg  <= S_NORM;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_MUL_FIN:
                begin
                    sig_reg    <= acc_reg[105:49];
                    sticky_reg <= |acc_reg[48:0];
                    re_reg     <= ea_reg + eb_reg - 14'sd1023;
                    state_reg  <= S_NORM;
                end
                S_NORM:
                begin
                    if (sig_reg[56])
                    begin
                        sig_reg    <= {1'b0, sig_reg[56:1]};
                        sticky_reg <= sticky_reg | sig_reg[0];
                        re_reg     <= re_reg + 14'sd1;
                    end
                    else if (re_reg < 14'sd1)
                    begin
                        // far below the subnormal range everything lands in sticky
                        if (re_reg < -14'sd60)
                        begin
                            sticky_reg <= sticky_reg | (|sig_reg);
                            sig_reg    <= '0;
                            re_reg     <= 14'sd1;
                        end
                        else
                        begin
                            sig_reg    <= {1'b0, sig_reg[56:1]};
                            sticky_reg <= sticky_reg | sig_reg[0];
                            re_reg     <= re_reg + 14'sd1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    result_reg <= packed_val;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

[rtl/dtd_queue.sv]
// small command queue between the parser and the arithmetic sequencer
// depends on dtd_pkg
module dtd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dtd_pkg::cmd_t push_data,
    input  logic          pop,
    output dtd_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import dtd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + (PTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (PTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/dtd_front.sv]
// character parser: whitespace, signs, digits, point and exponent
// depends on dtd_pkg; feeds commands into dtd_queue
module dtd_front #(
    parameter int EXP_LIMIT = dtd_pkg::EXP_LIMIT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          q_full,
    output logic          q_push,
    output dtd_pkg::cmd_t q_data
);
    import dtd_pkg::*;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_INT,
        PH_FRAC,
        PH_EXPSIGN,
        PH_EXPDIG,
        PH_DONE
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic                 mneg_reg, mneg_next;
    logic                 eneg_reg, eneg_next;
    logic [EXP_CNT_W-1:0] exp_reg, exp_next;

    logic                 accept;
    logic                 is_digit, is_space, is_exp;
    logic [3:0]           dval;
    logic [15:0]          exp_prod;
    logic [EXP_CNT_W-1:0] exp_sat;
    logic                 digit_add, frac_add;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        is_space = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR));
        is_exp   = (s_tdata == CH_LO_E) || (s_tdata == CH_UP_E);
        dval     = s_tdata[3:0];
        // times ten as two shifts
        exp_prod = {exp_reg, 3'b000} + {3'b000, exp_reg, 1'b0} + {12'd0, dval};
        exp_sat  = (exp_prod > 16'(EXP_LIMIT)) ? EXP_CNT_W'(EXP_LIMIT)
                                               : exp_prod[EXP_CNT_W-1:0];

        phase_next = phase_reg;
        mneg_next  = mneg_reg;
        eneg_next  = eneg_reg;
        exp_next   = exp_reg;
        digit_add  = 1'b0;
        frac_add   = 1'b0;
        case (phase_reg)
            PH_SPACE:
            begin
                if (is_space)
                begin
                    phase_next = PH_SPACE;
                end
                else if (s_tdata == CH_MINUS)
                begin
                    mneg_next  = 1'b1;
                    phase_next = PH_INT;
                end
                else if (s_tdata == CH_PLUS)
                begin
                    phase_next = PH_INT;
                end
                else if (is_digit)
                begin
                    digit_add  = 1'b1;
                    phase_next = PH_INT;
                end
                else if (s_tdata == CH_POINT)
                begin
                    phase_next = PH_FRAC;
                end
                else if (is_exp)
                begin
                    phase_next = PH_EXPSIGN;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    digit_add = 1'b1;
                end
                else if (s_tdata == CH_POINT)
                begin
                    phase_next = PH_FRAC;
                end
                else if (is_exp)
                begin
                    phase_next = PH_EXPSIGN;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    digit_add = 1'b1;
                    frac_add  = 1'b1;
                end
                else if (is_exp)
                begin
                    phase_next = PH_EXPSIGN;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_EXPSIGN:
            begin
                if (s_tdata == CH_MINUS)
                begin
                    eneg_next  = 1'b1;
                    phase_next = PH_EXPDIG;
                end
                else if (s_tdata == CH_PLUS)
                begin
                    phase_next = PH_EXPDIG;
                end
                else if (is_digit)
                begin
                    exp_next   = exp_sat;
                    phase_next = PH_EXPDIG;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_EXPDIG:
            begin
                if (is_digit)
                begin
                    exp_next = exp_sat;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        q_push           = accept && (digit_add || s_tlast);
        q_data.add_digit = digit_add;
        q_data.frac      = frac_add;
        q_data.digit     = dval;
        q_data.finish    = s_tlast;
        q_data.mant_neg  = mneg_next;
        q_data.exp_neg   = eneg_next;
        q_data.exp_count = exp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            mneg_reg  <= 1'b0;
            eneg_reg  <= 1'b0;
            exp_reg   <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                phase_reg <= PH_SPACE;
                mneg_reg  <= 1'b0;
                eneg_reg  <= 1'b0;
                exp_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                mneg_reg  <= mneg_next;
                eneg_reg  <= eneg_next;
                exp_reg   <= exp_next;
            end
        end
    end

endmodule

[rtl/dtd_back.sv]
// arithmetic sequencer: mantissa and scale updates, final divide and power scaling
// depends on dtd_pkg and dtd_fpu
module dtd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dtd_pkg::cmd_t q_head,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata
);
    import dtd_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DMUL,
        B_DADD,
        B_SMUL,
        B_FDIV,
        B_POW,
        B_FSCALE,
        B_OUT
    } state_t;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [63:0]          m_reg;
    logic [63:0]          s_reg;
    logic [63:0]          p_reg;
    logic [63:0]          r_reg;
    logic [EXP_CNT_W-1:0] k_reg;
    logic                 call_reg;
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;

    fpu_req_t req;
    fpu_rsp_t rsp;
    logic     pow_more;
    logic     out_load;

    function automatic logic [63:0] digit_to_double(input logic [3:0] d);
        logic [15:0] hi;
        case (d)
            4'd1:    hi = 16'h3FF0;
            4'd2:    hi = 16'h4000;
            4'd3:    hi = 16'h4008;
            4'd4:    hi = 16'h4010;
            4'd5:    hi = 16'h4014;
            4'd6:    hi = 16'h4018;
            4'd7:    hi = 16'h401C;
            4'd8:    hi = 16'h4020;
            4'd9:    hi = 16'h4022;
            default: hi = 16'h0000;
        endcase
        return {hi, 48'd0};
    endfunction

    dtd_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // powers of ten stop early once they have overflowed
    assign pow_more = (k_reg != '0) && (p_reg != DBL_INF);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_load = (state_reg == B_OUT) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        req.valid = 1'b0;
        req.op    = FP_MUL;
        req.a     = m_reg;
        req.b     = DBL_TEN;
        case (state_reg)
            B_DMUL:
            begin
                req.valid = !call_reg;
            end
            B_DADD:
            begin
                req.valid = !call_reg;
                req.op    = FP_ADD;
                req.b     = digit_to_double(cmd_reg.digit);
            end
            B_SMUL:
            begin
                req.valid = !call_reg;
                req.a     = s_reg;
            end
            B_FDIV:
            begin
                req.valid = !call_reg;
                req.op    = FP_DIV;
                req.a     = {m_reg[63] ^ cmd_reg.mant_neg, m_reg[62:0]};
                req.b     = s_reg;
            end
            B_POW:
            begin
                req.valid = !call_reg && pow_more;
                req.a     = p_reg;
            end
            B_FSCALE:
            begin
                req.valid = !call_reg;
                req.op    = cmd_reg.exp_neg ? FP_DIV : FP_MUL;
                req.a     = r_reg;
                req.b     = p_reg;
            end
            default:
            begin
                req.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cmd_reg       <= '0;
            m_reg         <= DBL_ZERO;
            s_reg         <= DBL_ONE;
            p_reg         <= DBL_ONE;
            r_reg         <= DBL_ZERO;
            k_reg         <= '0;
            call_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (req.valid)
            begin
                call_reg <= 1'b1;
            end
            else if (rsp.done)
            begin
                call_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg <= q_head;
                        if (q_head.add_digit)
                        begin
                            state_reg <= B_DMUL;
                        end
                        else if (q_head.finish)
                        begin
                            state_reg <= B_FDIV;
                        end
                    end
                end
                B_DMUL:
                begin
                    if (rsp.done)
                    begin
                        m_reg     <= rsp.result;
                        state_reg <= B_DADD;
                    end
                end
                B_DADD:
                begin
                    if (rsp.done)
                    begin
                        m_reg <= rsp.result;
                        if (cmd_reg.frac)
                        begin
                            state_reg <= B_SMUL;
                        end
                        else if (cmd_reg.finish)
                        begin
                            state_reg <= B_FDIV;
                        end
                        else
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                B_SMUL:
                begin
                    if (rsp.done)
                    begin
                        s_reg     <= rsp.result;
                        state_reg <= cmd_reg.finish ? B_FDIV : B_IDLE;
                    end
                end
                B_FDIV:
                begin
                    if (rsp.done)
                    begin
                        r_reg     <= rsp.result;
                        p_reg     <= DBL_ONE;
                        k_reg     <= cmd_reg.exp_count;
                        state_reg <= B_POW;
                    end
                end
                B_POW:
                begin
                    if (rsp.done)
                    begin
                        p_reg <= rsp.result;
                        k_reg <= k_reg - EXP_CNT_W'(1);
                    end
                    else if (!call_reg && !pow_more)
                    begin
                        state_reg <= B_FSCALE;
                    end
                end
                B_FSCALE:
                begin
                    if (rsp.done)
                    begin
                        r_reg     <= rsp.result;
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_load)
                    begin
                        out_data_reg <= r_reg;
                        m_reg        <= DBL_ZERO;
                        s_reg        <= DBL_ONE;
                        state_reg    <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> call_reg)
        else $error("unit finished with no operation outstanding");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> !call_reg)
        else $error("operation issued while another is outstanding");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before transfer");
`endif

endmodule

[rtl/decimal_text_to_double_top.sv]
// top level of the decimal text to double parser
// depends on dtd_pkg, dtd_front, dtd_queue, dtd_back
//
// usage:
//   s_axis carries one ascii character per transfer in tdata, tlast marks the
//   last character of a string. m_axis carries one ieee double per string.
//   the parser takes a character per cycle while the command queue has room;
//   only mantissa digits and the last character cost arithmetic work.
//   the shared double unit multiplies, adds and divides; an operand that is
//   zero, infinite or nan is resolved without iteration, and subnormal
//   operands are first normalized bit by bit. an integer digit costs a
//   multiply and an add, a fraction digit also a multiply of the scale.
//   the last character adds the final divide, one multiply per unit of
//   exponent (until the power overflows) and one more multiply or divide.
//   the exponent saturates at EXP_LIMIT.
//   the result waits in an output register; parsing of the next string goes on
//   while it waits, and only the next result stalls on a blocked receiver.
//   after reset the parser is in its whitespace phase with zero value.
module decimal_text_to_double_top #(
    parameter int EXP_LIMIT = dtd_pkg::EXP_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] result_bits
);
    import dtd_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_in;
    cmd_t q_head;

    dtd_front #(
        .EXP_LIMIT (EXP_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    dtd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    dtd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule

[verif/tb.sv]
// testbench for decimal_text_to_double_top: streams character strings, predicts each double
// depends on dtd_pkg and the rtl of the parser; needs nothing else
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtd_pkg::*;

    localparam int  EXP_LIMIT  = 511;
    localparam longint MAX_CYCLES = 3000000;

    typedef enum int {
        PH_SPACE,
        PH_INT,
        PH_FRAC,
        PH_EXPSIGN,
        PH_EXPDIG,
        PH_DONE
    } phase_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    decimal_text_to_double_top #(.EXP_LIMIT(EXP_LIMIT)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // parser state as the block should hold it
    phase_t      phase;
    real         mant;
    real         scale;
    int unsigned exp_cnt;
    bit          mant_neg;
    bit          exp_neg;

    logic [63:0] expected_doubles[$];
    int          err_cnt;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_cycles;
    longint      cycle_cnt;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        err_cnt++;
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_exp_mark(input logic [7:0] c);
        return c == CH_LO_E || c == CH_UP_E;
    endfunction

    task automatic clear_parser();
        phase    = PH_SPACE;
        mant     = 0.0;
        scale    = 1.0;
        exp_cnt  = 0;
        mant_neg = 0;
        exp_neg  = 0;
    endtask

    task automatic add_exp_digit(input logic [7:0] c);
        int unsigned e;
        e = exp_cnt * 10 + (c - CH_ZERO);
        exp_cnt = (e > EXP_LIMIT) ? EXP_LIMIT : e;
    endtask

    task automatic advance_parser(input logic [7:0] c);
        case (phase)
            PH_SPACE:
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) ;
                else if (c == CH_MINUS) begin mant_neg = 1; phase = PH_INT; end
                else if (c == CH_PLUS) phase = PH_INT;
                else if (is_digit(c)) begin
                    mant = 10.0 * mant + real'(c - CH_ZERO);
                    phase = PH_INT;
                end
                else if (c == CH_POINT) phase = PH_FRAC;
                else if (is_exp_mark(c)) phase = PH_EXPSIGN;
                else phase = PH_DONE;
            PH_INT:
                if (is_digit(c)) mant = 10.0 * mant + real'(c - CH_ZERO);
                else if (c == CH_POINT) phase = PH_FRAC;
                else if (is_exp_mark(c)) phase = PH_EXPSIGN;
                else phase = PH_DONE;
            PH_FRAC:
                if (is_digit(c)) begin
                    mant  = 10.0 * mant + real'(c - CH_ZERO);
                    scale = scale * 10.0;
                end
                else if (is_exp_mark(c)) phase = PH_EXPSIGN;
                else phase = PH_DONE;
            PH_EXPSIGN:
                if (c == CH_MINUS) begin exp_neg = 1; phase = PH_EXPDIG; end
                else if (c == CH_PLUS) phase = PH_EXPDIG;
                else if (is_digit(c)) begin add_exp_digit(c); phase = PH_EXPDIG; end
                else phase = PH_DONE;
            PH_EXPDIG:
                if (is_digit(c)) add_exp_digit(c);
                else phase = PH_DONE;
            default: phase = PH_DONE;
        endcase
    endtask

    function automatic logic [63:0] parsed_double();
        real         r;
        real         p;
        logic [63:0] b;
        r = mant;
        // sign flipped on the bit pattern so that zero keeps its sign
        if (mant_neg) r = $bitstoreal($realtobits(r) ^ 64'h8000_0000_0000_0000);
        r = r / scale;
        p = 1.0;
        for (int k = 0; k < exp_cnt; k++) p = p * 10.0;
        r = exp_neg ? r / p : r * p;
        b = $realtobits(r);
        if (b[62:52] == 11'h7FF && b[51:0] != 0) b = DBL_QNAN;
        return b;
    endfunction

    task automatic send_char(input logic [7:0] c, input bit last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        advance_parser(c);
        if (last) begin
            expected_doubles.push_back(parsed_double());
            clear_parser();
        end
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // mostly well-formed numbers with random content, some noise bytes
    task automatic send_random_number();
        byte unsigned txt[$];
        int n;
        repeat ($urandom_range(3) == 0 ? $urandom_range(2) : 0)
            txt.push_back($urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
        case ($urandom_range(2))
            0: txt.push_back(CH_MINUS);
            1: txt.push_back(CH_PLUS);
            default: ;
        endcase
        n = ($urandom_range(19) == 0) ? $urandom_range(22) : $urandom_range(6);
        repeat (n) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(1)) begin
            txt.push_back(CH_POINT);
            repeat ($urandom_range(6)) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(2) == 0) begin
            txt.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
            case ($urandom_range(2))
                0: txt.push_back(CH_MINUS);
                1: txt.push_back(CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(3)) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(4) == 0)
            txt.insert($urandom_range(txt.size()), 8'($urandom_range(255)));
        if (txt.size() == 0) txt.push_back(8'($urandom_range(255)));
        for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_text("  -12.5e3");
        send_text("\t\n\v\f\r7");
        send_text("-");
        send_text("0e400");
        send_text("1e999");
        send_text("2E-400");
        send_text("1e+-2");
        send_text("12x34");
        send_char(8'hFF, 1);
        send_char(8'h00, 1);
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int strings);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (strings) send_random_number();
    endtask

    // receiver blocks for a long stretch while strings keep coming
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 4000;
        repeat (12) send_random_number();
    endtask

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_doubles.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            else if (m_axis_tdata !== expected_doubles[0])
                report_mismatch($sformatf("result_bits %h, want %h",
                                          m_axis_tdata, expected_doubles.pop_front()));
            else
                void'(expected_doubles.pop_front());
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("decimal_text_to_double_top regression: fail");
            $finish;
        end
    end

    initial begin
        cycle_cnt     = 0;
        err_cnt       = 0;
        hold_cycles   = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        clear_parser();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(33, 60, 35);
        test_backpressure();
        test_random(60, 33, 35);
        test_random(0, 0, 35);

        s_axis_tvalid <= 1'b0;
        while (expected_doubles.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_cnt == 0)
            $display("decimal_text_to_double_top regression: pass");
        else
            $display("decimal_text_to_double_top regression: fail");
        $finish;
    end
endmodule

[decimal_text_to_double_top.f]
rtl/dtd_pkg.sv
rtl/dtd_fpu.sv
rtl/dtd_queue.sv
rtl/dtd_front.sv
rtl/dtd_back.sv
rtl/decimal_text_to_double_top.sv
verif/tb.sv
